// File: rtl/core/bmm_pkg.sv
// ============================================================================
// bmm_pkg
// Shared constants and controller/datapath interface types for the
// bipartite maximum matching unit.
// ============================================================================
package bmm_pkg;

    // Default number of vertices on each side.
    localparam int MAX_VERTICES_DEF = 64;

    // Width of one adjacency row on the input word.
    localparam int ROW_W = 64;

    // Width of the vertex count register and of the result fields.
    localparam int VC_W = 7;

    // Vertex count after reset.
    localparam logic [VC_W-1:0] VC_RESET = 7'd64;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic row_wr;         // store the accepted row and advance the row pointer
        logic run_init;       // clear partners and counters before a run
        logic root_start;     // open a search from the current root vertex
        logic scan_adv;       // skip the current right vertex
        logic hit_take;       // mark the current right vertex visited, read its partner
        logic push;           // descend into the partner of the right vertex just taken
        logic pop_rd;         // drop the top frame and read the one below it
        logic top_load;       // load the top frame from the stack read data
        logic adj_from_stack; // with top_load, also fetch that frame's row
        logic aug_wr;         // record the top frame's edge in the matching
        logic root_hit;       // root ended with an augmenting path
        logic root_miss;      // root ended without an augmenting path
        logic result_load;    // load the result word and clear the row store
    } bmm_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic u_end;        // all roots have been processed
        logic scan_end;     // the top frame has no right vertex left to try
        logic scan_hit;     // the current right vertex is adjacent and unvisited
        logic partner_free; // the right vertex just taken is unmatched
        logic depth_one;    // the stack holds only the root frame
        logic out_free;     // the result register can take a new word
    } bmm_status_t;

endpackage

// File: rtl/core/bmm_ctrl.sv
// ============================================================================
// bmm_ctrl
// Controller state machine: sequences row loading, the depth-first
// augmenting searches and the hand-off of the result word.
// ============================================================================
module bmm_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 row_valid,
    input  logic                 row_last,
    output logic                 row_ready,
    input  bmm_pkg::bmm_status_t status,
    output bmm_pkg::bmm_cmd_t    cmd
);
    import bmm_pkg::*;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_INIT  = 4'd1;
    localparam logic [3:0] S_ROOT  = 4'd2;
    localparam logic [3:0] S_SCAN  = 4'd3;
    localparam logic [3:0] S_CHK   = 4'd4;
    localparam logic [3:0] S_POP   = 4'd5;
    localparam logic [3:0] S_AUG   = 4'd6;
    localparam logic [3:0] S_AUGLD = 4'd7;
    localparam logic [3:0] S_DONE  = 4'd8;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    assign row_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (row_valid)
                begin
                    cmd.row_wr = 1'b1;
                    if (row_last)
                    begin
                        state_next = S_INIT;
                    end
                end
            end
            S_INIT:
            begin
                cmd.run_init = 1'b1;
                state_next   = S_ROOT;
            end
            S_ROOT:
            begin
                if (status.u_end)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.root_start = 1'b1;
                    state_next     = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (status.scan_end)
                begin
                    if (status.depth_one)
                    begin
                        cmd.root_miss = 1'b1;
                        state_next    = S_ROOT;
                    end
                    else
                    begin
                        cmd.pop_rd = 1'b1;
                        state_next = S_POP;
                    end
                end
                else if (status.scan_hit)
                begin
                    cmd.hit_take = 1'b1;
                    state_next   = S_CHK;
                end
                else
                begin
                    cmd.scan_adv = 1'b1;
                end
            end
            S_CHK:
            begin
                if (status.partner_free)
                begin
                    state_next = S_AUG;
                end
                else
                begin
                    cmd.push   = 1'b1;
                    state_next = S_SCAN;
                end
            end
            S_POP:
            begin
                cmd.top_load       = 1'b1;
                cmd.adj_from_stack = 1'b1;
                state_next         = S_SCAN;
            end
            S_AUG:
            begin
                cmd.aug_wr = 1'b1;
                if (status.depth_one)
                begin
                    cmd.root_hit = 1'b1;
                    state_next   = S_ROOT;
                end
                else
                begin
                    cmd.pop_rd = 1'b1;
                    state_next = S_AUGLD;
                end
            end
            S_AUGLD:
            begin
                cmd.top_load = 1'b1;
                state_next   = S_AUG;
            end
            S_DONE:
            begin
                if (status.out_free)
                begin
                    cmd.result_load = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// File: rtl/core/bmm_datapath.sv
// ============================================================================
// bmm_datapath
// Row store, partner memory, search stack, visit marks, counters and the
// result register of the matching unit.
// ============================================================================
module bmm_datapath #(
    parameter int MAX_VERTICES = bmm_pkg::MAX_VERTICES_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_write,
    input  logic [bmm_pkg::VC_W-1:0]  vertex_count,
    input  logic [bmm_pkg::ROW_W-1:0] row_bits,
    input  bmm_pkg::bmm_cmd_t         cmd,
    output bmm_pkg::bmm_status_t      status,
    output logic                      result_valid,
    input  logic                      result_ready,
    output logic [bmm_pkg::VC_W-1:0]  match_count,
    output logic [bmm_pkg::VC_W-1:0]  independent_size
);
    import bmm_pkg::*;

    localparam int N  = MAX_VERTICES;
    localparam int IW = $clog2(N);
    localparam int CW = $clog2(N + 1);
    localparam int SW = IW + CW;

    // Configuration and row loading.
    logic [VC_W-1:0] vc_reg;
    logic [CW-1:0]   row_ptr_reg;
    logic [CW-1:0]   n_eff;
    logic            adj_we;

    // Memories and their registered read data.
    logic [N-1:0]  adj_mem [N];
    logic [N-1:0]  row_q_reg;
    logic          row_ok_reg;
    logic [IW-1:0] rp_mem [N];
    logic [IW-1:0] rp_q_reg;
    logic [N-1:0]  rp_vld_reg;
    logic [SW-1:0] stk_mem [N];
    logic [SW-1:0] stk_q_reg;

    // Search state.
    logic [N-1:0]  visited_reg;
    logic [IW-1:0] top_left_reg;
    logic [CW-1:0] top_next_reg;
    logic [CW-1:0] depth_reg;
    logic [CW-1:0] u_reg;
    logic [CW-1:0] match_reg;
    logic [IW-1:0] hit_j_reg;

    logic [IW-1:0] j_idx;
    logic [IW-1:0] aug_idx;
    logic [CW-1:0] next_m1;
    logic [CW-1:0] depth_m1;
    logic [CW-1:0] depth_m2;
    logic          adj_rd;
    logic [IW-1:0] adj_addr;

    // Result register.
    logic            out_valid_reg;
    logic [VC_W-1:0] out_match_reg;
    logic [VC_W-1:0] out_ind_reg;

    assign n_eff    = (vc_reg > VC_W'(N)) ? CW'(N) : vc_reg[CW-1:0];
    assign adj_we   = cmd.row_wr && (row_ptr_reg < CW'(N));
    assign j_idx    = top_next_reg[IW-1:0];
    assign next_m1  = top_next_reg - CW'(1);
    assign aug_idx  = next_m1[IW-1:0];
    assign depth_m1 = depth_reg - CW'(1);
    assign depth_m2 = depth_reg - CW'(2);

    // The row of the new top frame is fetched whenever a frame is opened or the search returns to the frame below.
    assign adj_rd = cmd.root_start || cmd.push || (cmd.top_load && cmd.adj_from_stack);

    always_comb
    begin
        if (cmd.root_start)
        begin
            adj_addr = u_reg[IW-1:0];
        end
        else if (cmd.push)
        begin
            adj_addr = rp_q_reg;
        end
        else
        begin
            adj_addr = stk_q_reg[SW-1:CW];
        end
    end

    assign status.u_end        = (u_reg >= n_eff);
    assign status.scan_end     = (top_next_reg >= n_eff);
    assign status.scan_hit     = row_ok_reg && row_q_reg[j_idx] && !visited_reg[j_idx];
    assign status.partner_free = !rp_vld_reg[hit_j_reg];
    assign status.depth_one    = (depth_reg == CW'(1));
    assign status.out_free     = !out_valid_reg || result_ready;

    // Rows at or beyond the fill count read as zero.
    always_ff @(posedge clk)
    begin
        if (adj_we)
        begin
            adj_mem[row_ptr_reg[IW-1:0]] <= row_bits[N-1:0];
        end
        if (adj_rd)
        begin
            row_q_reg  <= adj_mem[adj_addr];
            row_ok_reg <= (CW'(adj_addr) < row_ptr_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.aug_wr)
        begin
            rp_mem[aug_idx] <= top_left_reg;
        end
        if (cmd.hit_take)
        begin
            rp_q_reg <= rp_mem[j_idx];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.push)
        begin
            stk_mem[depth_m1[IW-1:0]] <= {top_left_reg, top_next_reg};
        end
        if (cmd.pop_rd)
        begin
            stk_q_reg <= stk_mem[depth_m2[IW-1:0]];
        end
    end

    // Top frame and result data need no reset.
    always_ff @(posedge clk)
    begin
        if (cmd.root_start)
        begin
            top_left_reg <= u_reg[IW-1:0];
            top_next_reg <= '0;
        end
        else if (cmd.push)
        begin
            top_left_reg <= rp_q_reg;
            top_next_reg <= '0;
        end
        else if (cmd.top_load)
        begin
            top_left_reg <= stk_q_reg[SW-1:CW];
            top_next_reg <= stk_q_reg[CW-1:0];
        end
        else if (cmd.scan_adv || cmd.hit_take)
        begin
            top_next_reg <= top_next_reg + CW'(1);
        end
        if (cmd.hit_take)
        begin
            hit_j_reg <= j_idx;
        end
        if (cmd.result_load)
        begin
            out_match_reg <= VC_W'(match_reg);
            out_ind_reg   <= VC_W'(n_eff) - VC_W'(match_reg >> 1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vc_reg        <= VC_RESET;
            row_ptr_reg   <= '0;
            rp_vld_reg    <= '0;
            visited_reg   <= '0;
            depth_reg     <= '0;
            u_reg         <= '0;
            match_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                vc_reg <= vertex_count;
            end

            if (cmd.result_load)
            begin
                row_ptr_reg <= '0;
            end
            else if (adj_we)
            begin
                row_ptr_reg <= row_ptr_reg + CW'(1);
            end

            if (cmd.run_init)
            begin
                rp_vld_reg <= '0;
            end
            else if (cmd.aug_wr)
            begin
                rp_vld_reg[aug_idx] <= 1'b1;
            end

            if (cmd.root_start)
            begin
                visited_reg <= '0;
            end
            else if (cmd.hit_take)
            begin
                visited_reg[j_idx] <= 1'b1;
            end

            if (cmd.root_start)
            begin
                depth_reg <= CW'(1);
            end
            else if (cmd.push)
            begin
                depth_reg <= depth_reg + CW'(1);
            end
            else if (cmd.pop_rd)
            begin
                depth_reg <= depth_m1;
            end

            if (cmd.run_init)
            begin
                u_reg     <= '0;
                match_reg <= '0;
            end
            else
            begin
                if (cmd.root_hit || cmd.root_miss)
                begin
                    u_reg <= u_reg + CW'(1);
                end
                if (cmd.root_hit)
                begin
                    match_reg <= match_reg + CW'(1);
                end
            end

            if (cmd.result_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign result_valid     = out_valid_reg;
    assign match_count      = out_match_reg;
    assign independent_size = out_ind_reg;

endmodule

// File: rtl/core/bipartite_max_matching_unit.sv
// ============================================================================
// bipartite_max_matching_unit
// Maximum bipartite matching by augmenting paths over a loaded adjacency
// matrix, with a single result word per matrix.
// ============================================================================
//
// Rows are loaded one word per cycle while row_ready is high, the left vertex
// index being the order of arrival; bit i of a row is an edge to right vertex
// i, and only the low MAX_VERTICES bits are stored. Rows past MAX_VERTICES are
// dropped, and rows never loaded read as zero. The word marked row_last starts
// the matching over the first min(vertex_count, MAX_VERTICES) vertices. While
// the search runs, row_ready is low. The last row is followed by a setup step
// (S_INIT), and the search then tries one candidate right vertex per cycle in
// the frame on top of the stack, pausing to check each candidate taken, so its
// length is set by that scan. Each root has a setup step (S_ROOT), then a step
// for every candidate examined in every frame, a partner check (S_CHK) for
// each candidate taken, a step at the end of each frame's scan and another
// (S_POP) to return to the frame below, and an S_AUG and an S_AUGLD step for
// each edge written back along an augmenting path except the root's edge,
// which takes only S_AUG. Once the last root is done, S_ROOT finds that no
// root is left and S_DONE loads the result word into the output register,
// empties the row store and returns row_ready high; if the previous word has
// not been taken yet, the unit waits in that step with row_ready low. The next
// matrix's rows may be loaded while the new result word still waits for
// result_ready. No clearing pass is needed after reset. vertex_count is to be
// written through cfg_write only while the unit is idle; the unit itself
// leaves this to the user.
//
module bipartite_max_matching_unit #(
    parameter int MAX_VERTICES = bmm_pkg::MAX_VERTICES_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_write,
    input  logic [bmm_pkg::VC_W-1:0]  vertex_count,
    input  logic                      row_valid,
    output logic                      row_ready,
    input  logic [bmm_pkg::ROW_W-1:0] row_bits,
    input  logic                      row_last,
    output logic                      result_valid,
    input  logic                      result_ready,
    output logic [bmm_pkg::VC_W-1:0]  match_count,
    output logic [bmm_pkg::VC_W-1:0]  independent_size
);
    import bmm_pkg::*;

    bmm_cmd_t    cmd;
    bmm_status_t status;

    // The controller issues one command set per cycle and follows the
    // datapath status to walk the depth-first search.
    bmm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .row_valid (row_valid),
        .row_last  (row_last),
        .row_ready (row_ready),
        .status    (status),
        .cmd       (cmd)
    );

    // The datapath holds the row store, the partner memory, the explicit
    // search stack and the result register.
    bmm_datapath #(
        .MAX_VERTICES (MAX_VERTICES)
    ) u_datapath (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_write        (cfg_write),
        .vertex_count     (vertex_count),
        .row_bits         (row_bits),
        .cmd              (cmd),
        .status           (status),
        .result_valid     (result_valid),
        .result_ready     (result_ready),
        .match_count      (match_count),
        .independent_size (independent_size)
    );

endmodule

// File: rtl/core/bmm_checker.sv
// ============================================================================
// bmm_checker
// Port-level checks for the bipartite maximum matching unit, bound to the
// top level.
// ============================================================================
module bmm_checker #(
    parameter int MAX_VERTICES = bmm_pkg::MAX_VERTICES_DEF
) (
    input logic                      clk,
    input logic                      rst_n,
    input logic                      cfg_write,
    input logic [bmm_pkg::VC_W-1:0]  vertex_count,
    input logic                      row_valid,
    input logic                      row_ready,
    input logic [bmm_pkg::ROW_W-1:0] row_bits,
    input logic                      row_last,
    input logic                      result_valid,
    input logic                      result_ready,
    input logic [bmm_pkg::VC_W-1:0]  match_count,
    input logic [bmm_pkg::VC_W-1:0]  independent_size
);
    import bmm_pkg::*;

    // A stalled result word holds its value.
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=>
            result_valid && $stable(match_count) && $stable(independent_size))
        else $error("result word changed while stalled");

    // The last row of a matrix starts a search, which blocks further rows.
    a_busy_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        row_valid && row_ready && row_last |=> !row_ready)
        else $error("rows accepted during the matching search");

    // A new result word appears only as the search ends and loading resumes.
    a_result_at_end: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> row_ready)
        else $error("result appeared while the search was still running");

    // The matching never exceeds the vertex bound, and half of it never
    // exceeds the reported independent size.
    a_result_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |->
            (match_count <= VC_W'(MAX_VERTICES)) && (independent_size >= (match_count >> 1)))
        else $error("result word out of range");

endmodule

bind bipartite_max_matching_unit bmm_checker #(
    .MAX_VERTICES (MAX_VERTICES)
) u_bmm_checker (.*);

// File: sim/matching_checker.sv
// ============================================================================
// matching_checker
// Watches the row, result and configuration ports of the matching unit,
// predicts each result word from the rows it has seen and compares them.
// ============================================================================
module matching_checker (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_write,
    input  logic [bmm_pkg::VC_W-1:0]  vertex_count,
    input  logic                      row_valid,
    input  logic                      row_ready,
    input  logic [bmm_pkg::ROW_W-1:0] row_bits,
    input  logic                      row_last,
    input  logic                      result_valid,
    input  logic                      result_ready,
    input  logic [bmm_pkg::VC_W-1:0]  match_count,
    input  logic [bmm_pkg::VC_W-1:0]  independent_size,
    output int unsigned               fail_count,
    output int unsigned               pending,
    output int unsigned               results_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NV = bmm_pkg::MAX_VERTICES_DEF;

    typedef struct packed {
        logic [bmm_pkg::VC_W-1:0] match_val;
        logic [bmm_pkg::VC_W-1:0] indep;
    } matching_result_t;

    logic [bmm_pkg::ROW_W-1:0] adj_rows [NV];
    int unsigned               next_row;
    logic [bmm_pkg::VC_W-1:0]  count_reg;
    matching_result_t          expected_matchings [$];
    int unsigned               errs = 0;
    int unsigned               checked = 0;

    // Size of a maximum matching over the first n vertices, by augmenting
    // paths from each free left vertex with fresh visit marks per root.
    function automatic int max_matching_size(input int n);
        int                        lpart [NV];
        int                        rpart [NV];
        int                        frame_left [NV+1];
        int                        frame_next [NV+1];
        logic [bmm_pkg::ROW_W-1:0] mask, row, seen;
        int                        depth, j, k, root, total;
        bit                        found;
        mask = (n >= NV) ? '1 : ((64'd1 << n) - 64'd1);
        for (k = 0; k < NV; k++) begin
            lpart[k] = -1;
            rpart[k] = -1;
        end
        total = 0;
        for (root = 0; root < n; root++) begin
            if (lpart[root] >= 0)
                continue;
            seen = '0;
            depth = 1;
            frame_left[0] = root;
            frame_next[0] = 0;
            found = 1'b0;
            while (depth > 0 && !found) begin
                row = adj_rows[frame_left[depth-1]] & mask;
                j = frame_next[depth-1];
                while (j < n && (!row[j] || seen[j]))
                    j++;
                if (j >= n) begin
                    depth--;
                end else begin
                    seen[j] = 1'b1;
                    frame_next[depth-1] = j + 1;
                    if (rpart[j] < 0) begin
                        // Flip every edge along the path, from the deepest frame back to the root.
                        for (k = depth - 1; k >= 0; k--) begin
                            rpart[frame_next[k]-1] = frame_left[k];
                            lpart[frame_left[k]] = frame_next[k] - 1;
                        end
                        found = 1'b1;
                    end else begin
                        frame_left[depth] = rpart[j];
                        frame_next[depth] = 0;
                        depth++;
                    end
                end
            end
            if (found)
                total++;
        end
        return total;
    endfunction

    always @(posedge clk or negedge rst_n) begin
        matching_result_t want;
        int               n, size, indep_i;
        if (!rst_n) begin
            foreach (adj_rows[i])
                adj_rows[i] = '0;
            next_row = 0;
            count_reg = bmm_pkg::VC_RESET;
            expected_matchings.delete();
        end else begin
            if (cfg_write)
                count_reg = vertex_count;
            if (result_valid && result_ready) begin
                if (expected_matchings.size() == 0) begin
                    errs++;
                    $display("%0t: result word with none expected: match_count %0d",
                             $time, match_count);
                end else begin
                    want = expected_matchings.pop_front();
                    checked++;
                    if (match_count !== want.match_val) begin
                        errs++;
                        $display("%0t: match_count expected %0d actual %0d",
                                 $time, want.match_val, match_count);
                    end
                    if (independent_size !== want.indep) begin
                        errs++;
                        $display("%0t: independent_size expected %0d actual %0d",
                                 $time, want.indep, independent_size);
                    end
                end
            end
            if (row_valid && row_ready) begin
                // Rows past the store's depth are dropped; the pointer holds.
                if (next_row < NV) begin
                    adj_rows[next_row] = row_bits;
                    next_row++;
                end
                if (row_last) begin
                    n = (count_reg > NV) ? NV : int'(count_reg);
                    size = max_matching_size(n);
                    indep_i = n - size / 2;
                    want.match_val = size[bmm_pkg::VC_W-1:0];
                    want.indep = indep_i[bmm_pkg::VC_W-1:0];
                    expected_matchings.push_back(want);
                    foreach (adj_rows[i])
                        adj_rows[i] = '0;
                    next_row = 0;
                end
            end
        end
        pending <= expected_matchings.size();
        fail_count <= errs;
        results_checked <= checked;
    end

endmodule

// File: sim/testbench.sv
// ============================================================================
// testbench
// Drives adjacency matrices into the bipartite matching unit under random
// sender gaps and receiver stalls, across many vertex-count settings, and
// reports the verdict from the checker's failure count.
// ============================================================================
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NV          = bmm_pkg::MAX_VERTICES_DEF;
    localparam int RANDOM_ROWS = 950;
    // The stimulus holds only a handful of 64-vertex searches; this bound is
    // far past their worst case.
    localparam int CYCLE_LIMIT = 10_000_000;
    // The unit is idle once its result word is out; a settling margin is
    // kept before a register write all the same.
    localparam int SETTLE      = 8;
    localparam int HOLD_AT     = 400;
    localparam int HOLD_LEN    = 4000;

    // Shapes of adjacency rows. Chains force deep augmenting searches with a
    // lot of backtracking; random rows also set bits past the vertex count.
    typedef enum int {
        ROW_RANDOM,
        ROW_SPARSE,
        ROW_SINGLE,
        ROW_DENSE,
        ROW_CHAIN,
        ROW_EMPTY
    } row_shape_e;

    // Receiver stall patterns, switched at random points in the run.
    typedef enum int {
        READY_ALWAYS,
        READY_COIN,
        READY_SPARSE,
        READY_RUNS
    } ready_style_e;

    logic                      clk;
    logic                      rst_n;
    logic                      cfg_write;
    logic [bmm_pkg::VC_W-1:0]  vertex_count;
    logic                      row_valid;
    logic                      row_ready;
    logic [bmm_pkg::ROW_W-1:0] row_bits;
    logic                      row_last;
    logic                      result_valid;
    logic                      result_ready;
    logic [bmm_pkg::VC_W-1:0]  match_count;
    logic [bmm_pkg::VC_W-1:0]  independent_size;

    int unsigned fail_count;
    int unsigned pending;
    int unsigned results_checked;

    int unsigned cycle_count = 0;
    int unsigned rows_sent = 0;
    int unsigned matrices_sent = 0;
    int unsigned settings_used = 0;
    int          burst_left = 0;
    bit          steady = 1'b0;

    bipartite_max_matching_unit u_top (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_write        (cfg_write),
        .vertex_count     (vertex_count),
        .row_valid        (row_valid),
        .row_ready        (row_ready),
        .row_bits         (row_bits),
        .row_last         (row_last),
        .result_valid     (result_valid),
        .result_ready     (result_ready),
        .match_count      (match_count),
        .independent_size (independent_size)
    );

    matching_checker u_checker (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_write        (cfg_write),
        .vertex_count     (vertex_count),
        .row_valid        (row_valid),
        .row_ready        (row_ready),
        .row_bits         (row_bits),
        .row_last         (row_last),
        .result_valid     (result_valid),
        .result_ready     (result_ready),
        .match_count      (match_count),
        .independent_size (independent_size),
        .fail_count       (fail_count),
        .pending          (pending),
        .results_checked  (results_checked)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Watchdog: a hung handshake or a missing result word ends the run here.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d result words outstanding",
                     cycle_count, pending);
            $display("testbench: done, errors");
            $finish;
        end
    end

    // Offers one row word and returns at the edge where it is taken. The
    // sender works in bursts; at the start of each burst it may leave a gap
    // with valid low, unless the current phase runs without gaps.
    task automatic send_word(input logic [bmm_pkg::ROW_W-1:0] bits, input logic last);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = steady ? 0 : $urandom_range(0, 8);
            if (gap != 0)
            begin
                row_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        row_valid <= 1'b1;
        row_bits <= bits;
        row_last <= last;
        @(posedge clk);
        while (!row_ready)
            @(posedge clk);
        rows_sent++;
    endtask

    // The register may only change while the unit is idle: every expected
    // result word must have been taken first, and every matrix sent so far
    // ended with its last row, so the row store is empty too.
    task automatic write_vertex_count(input logic [bmm_pkg::VC_W-1:0] value);
        row_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        cfg_write <= 1'b1;
        vertex_count <= value;
        @(posedge clk);
        cfg_write <= 1'b0;
        settings_used++;
    endtask

    // Builds row u of a matrix over n vertices in the given shape.
    function automatic logic [bmm_pkg::ROW_W-1:0] make_row(input row_shape_e shape,
                                                          input int u, input int n);
        logic [bmm_pkg::ROW_W-1:0] r, mask;
        int                        k;
        r = '0;
        mask = (n >= NV) ? '1 : ((64'd1 << n) - 64'd1);
        if (n == 0)
            shape = ROW_RANDOM;
        case (shape)
            ROW_SPARSE:
            begin
                for (k = $urandom_range(1, 3); k > 0; k--)
                    r[$urandom_range(0, n - 1)] = 1'b1;
                // Now and then a stray bit that may lie past the vertex count.
                if ($urandom_range(0, 7) == 0)
                    r[$urandom_range(0, NV - 1)] = 1'b1;
            end
            ROW_SINGLE:
                r[$urandom_range(0, n - 1)] = 1'b1;
            ROW_DENSE:
                r = mask & ({$urandom, $urandom} | {$urandom, $urandom});
            ROW_CHAIN:
            begin
                // Row u reaches right vertices u-1 and u, so each new root has
                // to walk down the whole chain before it finds its own vertex.
                r[u % n] = 1'b1;
                if (u % n != 0)
                    r[u % n - 1] = 1'b1;
            end
            ROW_EMPTY:
                r = '0;
            default:
                r = {$urandom, $urandom};
        endcase
        return r;
    endfunction

    // Receiver: a changing stall pattern, and once, after a few hundred rows,
    // a long hold-off so that the unit finishes a matrix with its result
    // register still full and has to stall its row input.
    initial
    begin
        ready_style_e style;
        int           style_left, run_left, hold_left;
        bit           hold_done, level;
        style = READY_ALWAYS;
        style_left = 0;
        run_left = 0;
        hold_left = 0;
        hold_done = 1'b0;
        level = 1'b0;
        result_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_left != 0)
            begin
                result_ready <= 1'b0;
                hold_left--;
            end
            else if (!hold_done && rows_sent >= HOLD_AT)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_LEN - 1;
                result_ready <= 1'b0;
            end
            else
            begin
                if (style_left == 0)
                begin
                    style = ready_style_e'($urandom_range(0, 3));
                    style_left = $urandom_range(50, 300);
                end
                style_left--;
                case (style)
                    READY_ALWAYS:
                        result_ready <= 1'b1;
                    READY_COIN:
                        result_ready <= $urandom_range(0, 1);
                    READY_SPARSE:
                        result_ready <= ($urandom_range(0, 5) == 0);
                    default:
                    begin
                        if (run_left == 0)
                        begin
                            level = !level;
                            run_left = $urandom_range(1, 8);
                        end
                        run_left--;
                        result_ready <= level;
                    end
                endcase
            end
        end
    end

    // Stimulus: a short directed part, then random phases of matrices.
    initial
    begin
        row_shape_e  shape;
        int          vc, n, rows, phase, mats_left, budget, u;
        int unsigned rows_target, phase_end;
        bit          big_phase, overflow_done;

        rst_n <= 1'b0;
        cfg_write <= 1'b0;
        vertex_count <= bmm_pkg::VC_RESET;
        row_valid <= 1'b0;
        row_bits <= '0;
        row_last <= 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset count of 64: a single full row matches exactly once.
        send_word('1, 1'b1);
        // A count above the maximum saturates; two rows share one vertex.
        write_vertex_count(7'd127);
        send_word(64'h1, 1'b0);
        send_word(64'h1, 1'b1);
        // Empty graph: both outputs are zero whatever the rows hold.
        write_vertex_count(7'd0);
        send_word('1, 1'b1);
        // One vertex: an edge only past the count, then the one real edge.
        write_vertex_count(7'd1);
        send_word(~64'h1, 1'b1);
        send_word(64'h1, 1'b1);
        // Three vertices where the second root must push the first aside.
        write_vertex_count(7'd3);
        send_word(64'h3, 1'b0);
        send_word(64'h1, 1'b0);
        send_word(64'h4, 1'b1);
        // Only bits past the count, and a row that is never loaded.
        write_vertex_count(7'd2);
        send_word(~64'h3, 1'b1);
        // Top bit of the row on a full-size matrix.
        write_vertex_count(7'd64);
        send_word(64'h8000_0000_0000_0000, 1'b0);
        send_word(64'h8000_0000_0000_0000, 1'b1);

        rows_target = rows_sent + RANDOM_ROWS;
        phase = 0;
        overflow_done = 1'b0;
        while (rows_sent < rows_target)
        begin
            // Most phases keep the vertex count small so searches stay short;
            // every fifth runs one or two full-size matrices.
            big_phase = (phase % 5 == 3);
            if (big_phase)
            begin
                case ($urandom_range(0, 3))
                    0: vc = 64;
                    1: vc = 65;
                    2: vc = 100;
                    default: vc = 127;
                endcase
            end
            else if ($urandom_range(0, 7) == 0)
                vc = 0;
            else if ($urandom_range(0, 5) == 0)
                vc = $urandom_range(17, 40);
            else
                vc = $urandom_range(1, 16);
            write_vertex_count(vc[bmm_pkg::VC_W-1:0]);
            n = (vc > NV) ? NV : vc;
            steady = ($urandom_range(0, 3) == 0);
            mats_left = big_phase ? $urandom_range(1, 2) : 1000;
            budget = big_phase ? 1000 : $urandom_range(40, 120);
            phase_end = rows_sent + budget;
            while (mats_left > 0 && rows_sent < phase_end)
            begin
                // Mostly exactly n rows; some matrices stop short (the rest
                // read as zero) and some run past n. The first full-size
                // matrix overflows the row store so later rows are dropped.
                if (n == 0)
                    rows = $urandom_range(1, 3);
                else if (n == NV && !overflow_done)
                begin
                    rows = NV + $urandom_range(1, 6);
                    overflow_done = 1'b1;
                end
                else
                begin
                    case ($urandom_range(0, 9))
                        0, 1: rows = $urandom_range(1, (n > 1) ? n - 1 : 1);
                        2: rows = n + $urandom_range(1, 4);
                        default: rows = n;
                    endcase
                end
                shape = row_shape_e'($urandom_range(0, 5));
                for (u = 0; u < rows; u++)
                    send_word(make_row(($urandom_range(0, 9) == 0) ? ROW_RANDOM : shape,
                                       u, n),
                              u == rows - 1);
                matrices_sent++;
                mats_left--;
            end
            phase++;
        end

        // Drain: wait for every expected result word, then a short margin so
        // a stray extra word would still be seen by the checker.
        row_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        $display("Sent %0d row words forming %0d matrices under %0d vertex-count settings,",
                 rows_sent, matrices_sent + 8, settings_used);
        $display("with gaps, stalls and one long result hold-off; %0d result words compared.",
                 results_checked);
        if (fail_count == 0 && pending == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

endmodule
